// ===== rtl/occupancy_grid_frontier_update_unit_defines.svh =====
// Assertion macros shared by the occupancy grid frontier update unit
`ifndef OCCUPANCY_GRID_FRONTIER_UPDATE_UNIT_DEFINES_SVH
`define OCCUPANCY_GRID_FRONTIER_UPDATE_UNIT_DEFINES_SVH

// check on every clock edge outside reset
`define OGF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check on every clock edge, reset included
`define OGF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ogf_pkg.sv =====
// Package: map geometry, cell encoding, item and result types, helpers
`default_nettype none
package ogf_pkg;

	localparam int MAP_WIDTH  = 64;
	localparam int MAP_HEIGHT = 64;
	localparam int XW         = $clog2(MAP_WIDTH);
	localparam int YW         = $clog2(MAP_HEIGHT);
	localparam int AW         = XW + YW;
	localparam int CELLS      = MAP_WIDTH * MAP_HEIGHT;
	localparam int RW         = 7;
	localparam int CW         = 13;
	localparam int SW         = 16;
	localparam int MW         = (XW > YW) ? XW : YW;
	localparam int DW         = 2 * MW + 1;
	localparam int PAW        = 3;

	localparam logic [CW-1:0] CNT_MAX = '1;

	localparam logic [PAW-1:0] REG_MAP_WIDTH  = PAW'(0);
	localparam logic [PAW-1:0] REG_MAP_HEIGHT = PAW'(4);

	localparam logic [2:0] NB_CENTER = 3'd0;
	localparam logic [2:0] NB_LEFT   = 3'd1;
	localparam logic [2:0] NB_RIGHT  = 3'd2;
	localparam logic [2:0] NB_UP     = 3'd3;
	localparam logic [2:0] NB_DOWN   = 3'd4;
	localparam logic [2:0] NB_END    = 3'd5;

	typedef enum logic [1:0] {
		CS_UNKNOWN = 2'd0,
		CS_FREE    = 2'd1,
		CS_OCC     = 2'd2,
		CS_FRONT   = 2'd3
	} cell_state_t;

	typedef struct packed {
		logic        mark;
		cell_state_t state;
	} cell_word_t;

	typedef enum logic {
		ACT_SENSE  = 1'b0,
		ACT_COMMIT = 1'b1
	} action_t;

	typedef struct packed {
		action_t       action;
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic          occ;
		logic [XW-1:0] dx;
		logic [YW-1:0] dy;
	} item_t;

	typedef struct packed {
		logic          found;
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [SW-1:0] stamp;
		logic [CW-1:0] frontier_total;
		logic [CW-1:0] free_total;
		logic [CW-1:0] occupied_total;
	} result_t;

	typedef struct packed {
		logic clearing;
		logic res_valid;
	} eng_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_S_SEL,
		ST_S_EV,
		ST_C_RD,
		ST_C_EV,
		ST_N_SEL,
		ST_N_EV,
		ST_FIN,
		ST_REPORT
	} eng_state_t;

	function automatic logic nb_valid(input logic [2:0] k, input logic [XW-1:0] x,
		input logic [YW-1:0] y, input logic [RW-1:0] w, input logic [RW-1:0] h);
		logic ok;
		logic [RW-1:0] xe;
		logic [RW-1:0] ye;
		xe = RW'(x);
		ye = RW'(y);
		case (k)
			NB_CENTER: ok = (xe < w) && (ye < h);
			NB_LEFT:   ok = (xe != '0) && (xe < w) && (ye < h);
			NB_RIGHT:  ok = (xe + RW'(1) < w) && (ye < h);
			NB_UP:     ok = (ye != '0) && (xe < w) && (ye < h);
			NB_DOWN:   ok = (ye + RW'(1) < h) && (xe < w);
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic [AW-1:0] nb_addr(input logic [2:0] k, input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		logic [XW-1:0] nx;
		logic [YW-1:0] ny;
		nx = x;
		ny = y;
		case (k)
			NB_LEFT:  nx = x - XW'(1);
			NB_RIGHT: nx = x + XW'(1);
			NB_UP:    ny = y - YW'(1);
			NB_DOWN:  ny = y + YW'(1);
			default:  begin
				nx = x;
				ny = y;
			end
		endcase
		return {ny, nx};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/occupancy_grid_frontier_update_unit.sv =====
// Top level: configuration registers, front and back ends, result register
// Usage:
//  Items enter through push/full; a transfer happens when push is high and full low.
//  A sensed cell (action 0) updates the map and gives no result; a commit (action 1)
//  gives one result, held on the result ports while empty is low and taken by pop.
//  map_width and map_height sit at byte addresses 0 and 4 of the APB port; the user
//  must write them only while the block is idle, which the block does not enforce.
//  After reset the map memory is swept to unknown, one cell a cycle, during which
//  full stays high.
//  A sensed cell takes a start step, a select step for itself and each of the four
//  neighbour positions, a closing select step, and an update step for itself and
//  each neighbour in the region. A commit takes a start step, walks all 4096 cells
//  through a read, an evaluate and a finish step each, a marked cell in the region
//  adding one step per neighbour position tried, one per neighbour read and one more
//  when no unknown neighbour turns up, then a report step.
//  The single read port of the map memory sets this sequence of steps.
//  Items queue two deep ahead of the map engine, so pushes carry on while it works.
//  When the receiver does not pop, the result waits in the output register and the
//  engine holds in its report step until it is taken; no result is ever dropped.
`default_nettype none
module occupancy_grid_frontier_update_unit
	import ogf_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [PAW-1:0] paddr,
	input  wire logic [31:0]    pwdata,
	output logic      [31:0]    prdata,
	output logic                pready,
	input  wire logic           push,
	output logic                full,
	input  wire logic           action,
	input  wire logic [XW-1:0]  cell_x,
	input  wire logic [YW-1:0]  cell_y,
	input  wire logic           cell_is_occupied,
	input  wire logic [XW-1:0]  drone_x,
	input  wire logic [YW-1:0]  drone_y,
	output logic                empty,
	input  wire logic           pop,
	output logic                found,
	output logic      [XW-1:0]  target_x,
	output logic      [YW-1:0]  target_y,
	output logic      [SW-1:0]  target_stamp,
	output logic      [CW-1:0]  frontier_total,
	output logic      [CW-1:0]  free_total,
	output logic      [CW-1:0]  occupied_total
);

	logic [RW-1:0] map_width_q;
	logic [RW-1:0] map_height_q;
	logic [RW-1:0] w_eff;
	logic [RW-1:0] h_eff;
	logic          cfg_wr;
	item_t         item_in;
	item_t         item_q;
	logic          item_valid;
	logic          item_pop;
	eng_stat_t     stat;
	result_t       res;
	result_t       out_q;
	logic          out_valid_q;
	logic          res_ready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? 32'(map_height_q) : 32'(map_width_q);
	assign w_eff  = (map_width_q > RW'(MAP_WIDTH)) ? RW'(MAP_WIDTH) : map_width_q;
	assign h_eff  = (map_height_q > RW'(MAP_HEIGHT)) ? RW'(MAP_HEIGHT) : map_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= RW'(64);
			map_height_q <= RW'(64);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAP_HEIGHT[2]) map_height_q <= pwdata[RW-1:0];
			else map_width_q <= pwdata[RW-1:0];
		end
	end

	assign item_in.action = action_t'(action);
	assign item_in.x      = cell_x;
	assign item_in.y      = cell_y;
	assign item_in.occ    = cell_is_occupied;
	assign item_in.dx     = drone_x;
	assign item_in.dy     = drone_y;

	ogf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item_in    (item_in),
		.w          (w_eff),
		.h          (h_eff),
		.clearing   (stat.clearing),
		.item_pop   (item_pop),
		.item_valid (item_valid),
		.item_out   (item_q)
	);

	ogf_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.w          (w_eff),
		.h          (h_eff),
		.item_valid (item_valid),
		.item_in    (item_q),
		.item_pop   (item_pop),
		.res_ready  (res_ready),
		.stat       (stat),
		.res        (res)
	);

	assign res_ready = !out_valid_q;

	always_ff @(posedge clk) begin
		if (stat.res_valid && res_ready) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty          = !out_valid_q;
	assign found          = out_q.found;
	assign target_x       = out_q.x;
	assign target_y       = out_q.y;
	assign target_stamp   = out_q.stamp;
	assign frontier_total = out_q.frontier_total;
	assign free_total     = out_q.free_total;
	assign occupied_total = out_q.occupied_total;

endmodule
`default_nettype wire

// ===== rtl/ogf_ram.sv =====
// Generic single write port, single read port RAM with registered read
`default_nettype none
module ogf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ogf_front.sv =====
// Front end: accept items, drop sensed cells outside the region, queue the rest
`default_nettype none
module ogf_front
	import ogf_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire item_t         item_in,
	input  wire logic [RW-1:0] w,
	input  wire logic [RW-1:0] h,
	input  wire logic          clearing,
	input  wire logic          item_pop,
	output logic               item_valid,
	output item_t              item_out
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       xfer;
	logic       keep;
	logic       do_wr;
	logic       do_rd;

	assign full       = (cnt_q == 2'd2) || clearing;
	assign xfer       = push && !full;
	assign keep       = (item_in.action == ACT_COMMIT) ||
		nb_valid(NB_CENTER, item_in.x, item_in.y, w, h);
	assign do_wr      = xfer && keep;
	assign item_valid = (cnt_q != 2'd0);
	assign do_rd      = item_pop && item_valid;
	assign item_out   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ogf_engine.sv =====
// Back end: map clearing, sensed cell updates and the commit walk over the grid
`default_nettype none
`include "occupancy_grid_frontier_update_unit_defines.svh"
module ogf_engine
	import ogf_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [RW-1:0] w,
	input  wire logic [RW-1:0] h,
	input  wire logic          item_valid,
	input  wire item_t         item_in,
	output logic               item_pop,
	input  wire logic          res_ready,
	output eng_stat_t          stat,
	output result_t            res
);

	eng_state_t    st_q;
	eng_state_t    st_d;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] cx_q;
	logic [YW-1:0] cy_q;
	logic [2:0]    k_q;
	logic          occ_q;
	logic [XW-1:0] dx_q;
	logic [YW-1:0] dy_q;
	cell_word_t    cw_q;
	logic          promote_q;
	logic [CW-1:0] free_q;
	logic [CW-1:0] occn_q;
	logic [CW-1:0] total_q;
	logic [SW-1:0] scan_q;
	logic          found_q;
	logic [DW-1:0] best_q;
	logic [XW-1:0] bx_q;
	logic [YW-1:0] by_q;
	logic [SW-1:0] bs_q;

	logic          cell_we;
	logic [AW-1:0] cell_waddr;
	cell_word_t    cell_wdata;
	logic          cell_re;
	logic [AW-1:0] cell_raddr;
	cell_word_t    cell_rdata;
	logic [2:0]    cell_rraw;
	logic          stp_we;
	logic          stp_re;
	logic [SW-1:0] stp_rdata;

	logic          nbv;
	logic [AW-1:0] nba;
	logic [AW-1:0] ctr;
	logic          in_reg;
	logic          last;
	cell_word_t    sense_new;
	logic          add_free;
	logic          add_occ;
	cell_state_t   fs;
	logic [XW-1:0] ax;
	logic [YW-1:0] ay;
	logic [DW-1:0] dsq;
	logic          is_front;
	logic [SW-1:0] cur_stamp;

	assign nbv        = nb_valid(k_q, cx_q, cy_q, w, h);
	assign nba        = nb_addr(k_q, cx_q, cy_q);
	assign ctr        = {cy_q, cx_q};
	assign in_reg     = nb_valid(NB_CENTER, cx_q, cy_q, w, h);
	assign last       = (cx_q == XW'(MAP_WIDTH - 1)) && (cy_q == YW'(MAP_HEIGHT - 1));
	assign cell_rdata = cell_word_t'(cell_rraw);
	assign item_pop   = (st_q == ST_IDLE) && item_valid;

	ogf_ram #(.WIDTH(3), .DEPTH(CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (cell_re),
		.raddr (cell_raddr),
		.rdata (cell_rraw)
	);

	ogf_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stamp_ram (
		.clk   (clk),
		.we    (stp_we),
		.waddr (ctr),
		.wdata (scan_q),
		.re    (stp_re),
		.raddr (ctr),
		.rdata (stp_rdata)
	);

	always_comb begin
		sense_new = cell_rdata;
		add_free  = 1'b0;
		add_occ   = 1'b0;
		if (k_q == NB_CENTER) begin
			if (cell_rdata.state == CS_UNKNOWN) begin
				sense_new.state = occ_q ? CS_OCC : CS_FREE;
				add_occ         = occ_q;
				add_free        = !occ_q;
			end
			if (!occ_q) begin
				if (sense_new.state == CS_FRONT) begin
					sense_new.state = CS_FREE;
				end
				if (sense_new.state == CS_FREE) begin
					sense_new.mark = 1'b1;
				end
			end
		end else if (cell_rdata.state == CS_FRONT) begin
			sense_new.state = CS_FREE;
			sense_new.mark  = 1'b1;
		end
	end

	always_comb begin
		fs        = promote_q ? CS_FRONT : cw_q.state;
		ax        = (cx_q > dx_q) ? cx_q - dx_q : dx_q - cx_q;
		ay        = (cy_q > dy_q) ? cy_q - dy_q : dy_q - cy_q;
		dsq       = DW'(ax) * DW'(ax) + DW'(ay) * DW'(ay);
		is_front  = in_reg && (fs == CS_FRONT);
		cur_stamp = promote_q ? scan_q : stp_rdata;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: begin
				if (clr_q == '1) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					st_d = (item_in.action == ACT_SENSE) ? ST_S_SEL : ST_C_RD;
				end
			end
			ST_S_SEL: begin
				if (k_q == NB_END) st_d = ST_IDLE;
				else if (nbv) st_d = ST_S_EV;
			end
			ST_S_EV:  st_d = ST_S_SEL;
			ST_C_RD:  st_d = ST_C_EV;
			ST_C_EV: begin
				st_d = (cell_rdata.mark && in_reg) ? ST_N_SEL : ST_FIN;
			end
			ST_N_SEL: begin
				if (k_q == NB_END) st_d = ST_FIN;
				else if (nbv) st_d = ST_N_EV;
			end
			ST_N_EV: begin
				st_d = (cell_rdata.state == CS_UNKNOWN) ? ST_FIN : ST_N_SEL;
			end
			ST_FIN: begin
				st_d = last ? ST_REPORT : ST_C_RD;
			end
			ST_REPORT: begin
				if (res_ready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = nba;
		cell_wdata = sense_new;
		cell_re    = 1'b0;
		cell_raddr = nba;
		stp_we     = 1'b0;
		stp_re     = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				cell_we    = 1'b1;
				cell_waddr = clr_q;
				cell_wdata = '0;
			end
			ST_S_SEL, ST_N_SEL: begin
				cell_re = (k_q != NB_END) && nbv;
			end
			ST_S_EV: begin
				cell_we = 1'b1;
			end
			ST_C_RD: begin
				cell_re    = 1'b1;
				cell_raddr = ctr;
				stp_re     = 1'b1;
			end
			ST_FIN: begin
				cell_we          = 1'b1;
				cell_waddr       = ctr;
				cell_wdata.mark  = 1'b0;
				cell_wdata.state = fs;
				stp_we           = promote_q;
			end
			default: begin
				cell_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_q     <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			k_q       <= NB_CENTER;
			occ_q     <= 1'b0;
			dx_q      <= '0;
			dy_q      <= '0;
			cw_q      <= '0;
			promote_q <= 1'b0;
			free_q    <= '0;
			occn_q    <= '0;
			total_q   <= '0;
			scan_q    <= '0;
			found_q   <= 1'b0;
			best_q    <= '0;
			bx_q      <= '0;
			by_q      <= '0;
			bs_q      <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					if (item_valid) begin
						k_q   <= NB_CENTER;
						occ_q <= item_in.occ;
						dx_q  <= item_in.dx;
						dy_q  <= item_in.dy;
						if (item_in.action == ACT_SENSE) begin
							cx_q <= item_in.x;
							cy_q <= item_in.y;
						end else begin
							cx_q    <= '0;
							cy_q    <= '0;
							total_q <= '0;
							found_q <= 1'b0;
							best_q  <= '0;
							bx_q    <= '0;
							by_q    <= '0;
							bs_q    <= '0;
						end
					end
				end
				ST_S_SEL, ST_N_SEL: begin
					if ((k_q != NB_END) && !nbv) k_q <= k_q + 3'd1;
				end
				ST_S_EV: begin
					k_q <= k_q + 3'd1;
					if (add_free && (free_q != CNT_MAX)) free_q <= free_q + CW'(1);
					if (add_occ && (occn_q != CNT_MAX)) occn_q <= occn_q + CW'(1);
				end
				ST_C_EV: begin
					cw_q      <= cell_rdata;
					k_q       <= NB_LEFT;
					promote_q <= 1'b0;
				end
				ST_N_EV: begin
					if (cell_rdata.state == CS_UNKNOWN) promote_q <= 1'b1;
					else k_q <= k_q + 3'd1;
				end
				ST_FIN: begin
					if (is_front) begin
						if (total_q != CNT_MAX) total_q <= total_q + CW'(1);
						if (!found_q || (dsq < best_q)) begin
							found_q <= 1'b1;
							best_q  <= dsq;
							bx_q    <= cx_q;
							by_q    <= cy_q;
							bs_q    <= cur_stamp;
						end
					end
					if (cx_q == XW'(MAP_WIDTH - 1)) begin
						cx_q <= '0;
						cy_q <= cy_q + YW'(1);
					end else begin
						cx_q <= cx_q + XW'(1);
					end
				end
				ST_REPORT: begin
					if (res_ready) scan_q <= scan_q + SW'(1);
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	assign stat.clearing      = (st_q == ST_CLEAR);
	assign stat.res_valid     = (st_q == ST_REPORT);
	assign res.found          = found_q;
	assign res.x              = bx_q;
	assign res.y              = by_q;
	assign res.stamp          = bs_q;
	assign res.frontier_total = total_q;
	assign res.free_total     = free_q;
	assign res.occupied_total = occn_q;

	`OGF_ASSERT(a_pop_only_idle, item_pop |-> (st_q == ST_IDLE), "item taken outside idle")
	`OGF_ASSERT(a_scan_advance, (stat.res_valid && res_ready) |=> (scan_q == $past(scan_q) + SW'(1)), "scan count did not advance on report")
	`OGF_ASSERT(a_no_write_report, (st_q == ST_REPORT) |-> (!cell_we && !stp_we), "map written while reporting")
	`OGF_ASSERT_ALWAYS(a_total_bound, total_q <= CW'(CELLS), "frontier total beyond map size")

endmodule
`default_nettype wire
